[rtl/gnss_raw_frame_tracker_defines.svh]
// assertion helpers shared by the front, queue and back modules
`ifndef GNSS_RAW_FRAME_TRACKER_DEFINES_SVH
`define GNSS_RAW_FRAME_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on aclk, off during reset
`define GRFT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grft assertion failed");
// next-cycle implication on aclk, off during reset
`define GRFT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grft assertion failed");
`else
`define GRFT_ASSERT_IMP(lbl, ante, cons)
`define GRFT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/grft_pkg.sv]
`timescale 1ns / 1ps

package grft_pkg;

    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int HP_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CLASS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SVID     = 3'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] CLASS_RST    = 8'h02;
    localparam logic [BYTE_W-1:0] ID_RST       = 8'h10;
    localparam logic [BYTE_W-1:0] INTERVAL_RST = 8'd16;
    localparam logic [BYTE_W-1:0] LAST_SVID_RST = 8'd32;

    // frame constants
    localparam logic [BYTE_W-1:0] SYNC_1     = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_2     = 8'h62;
    localparam logic [BYTE_W-1:0] CLS_AID    = 8'h0B;
    localparam logic [BYTE_W-1:0] ID_HUI     = 8'h02;
    localparam logic [BYTE_W-1:0] CLS_RXM    = 8'h02;
    localparam logic [BYTE_W-1:0] ID_EPH     = 8'h31;
    localparam logic [BYTE_W-1:0] EPH_LEN_LO = 8'h01;
    localparam logic [BYTE_W-1:0] EPH_LEN_HI = 8'h00;
    localparam logic [BYTE_W-1:0] HUI_LEN_LO = 8'h00;
    localparam logic [BYTE_W-1:0] HUI_LEN_HI = 8'h00;

    // fletcher sums of the fixed body bytes; the svid adds once to each sum
    localparam logic [BYTE_W-1:0] EPH_CKA_BASE =
        8'(CLS_RXM + ID_EPH + EPH_LEN_LO + EPH_LEN_HI);
    localparam logic [BYTE_W-1:0] EPH_CKB_BASE =
        8'(5 * CLS_RXM + 4 * ID_EPH + 3 * EPH_LEN_LO + 2 * EPH_LEN_HI);
    localparam logic [BYTE_W-1:0] HUI_CKA =
        8'(CLS_AID + ID_HUI + HUI_LEN_LO + HUI_LEN_HI);
    localparam logic [BYTE_W-1:0] HUI_CKB =
        8'(4 * CLS_AID + 3 * ID_HUI + 2 * HUI_LEN_LO + HUI_LEN_HI);

    localparam logic [IDX_W-1:0] EPH_LAST = 4'd8;
    localparam logic [IDX_W-1:0] HUI_LAST = 4'd7;

    // header positions
    localparam logic [HP_W-1:0] HP_IDLE       = 4'd0;
    localparam logic [HP_W-1:0] HP_GOT_SYNC1  = 4'd1;
    localparam logic [HP_W-1:0] HP_GOT_SYNC2  = 4'd2;
    localparam logic [HP_W-1:0] HP_GOT_CLASS  = 4'd3;
    localparam logic [HP_W-1:0] HP_TIME_FIRST = 4'd7;
    localparam logic [HP_W-1:0] HP_TIME_LAST  = 4'd10;
    localparam logic [HP_W-1:0] HP_SATS       = 4'd13;

    // divide by 1000 as multiply by ceil(2^41/1000), exact below 2^31
    localparam int              MS_PER_S    = 1000;
    localparam int              RECIP_SHIFT = 41;
    localparam logic [31:0]     RECIP       = 32'd2199023256;
    localparam int              Q_W         = 22;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_FIRST,
        ST_EPH,
        ST_HEALTH,
        ST_STATUS
    } grft_bstate_t;

    // one accepted byte: status snapshot plus the polls it triggers
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [BYTE_W-1:0] sats;
        logic              fresh;
        logic              eph;
        logic [BYTE_W-1:0] svid;
        logic              health;
    } grft_job_t;

    typedef struct packed {
        grft_job_t job;
        logic      need_round;
        logic      wb;
    } grft_stage_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] tx;
        logic              frame_end;
        logic              run_end;
        logic [TIME_W-1:0] time_ms;
        logic [BYTE_W-1:0] sats;
        logic              fresh;
    } grft_res_t;

    function automatic logic [BYTE_W-1:0] eph_byte(input logic [IDX_W-1:0] idx,
                                                   input logic [BYTE_W-1:0] svid);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = SYNC_1;
            4'd1:    b = SYNC_2;
            4'd2:    b = CLS_RXM;
            4'd3:    b = ID_EPH;
            4'd4:    b = EPH_LEN_LO;
            4'd5:    b = EPH_LEN_HI;
            4'd6:    b = svid;
            4'd7:    b = EPH_CKA_BASE + svid;
            4'd8:    b = EPH_CKB_BASE + svid;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] hui_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = SYNC_1;
            4'd1:    b = SYNC_2;
            4'd2:    b = CLS_AID;
            4'd3:    b = ID_HUI;
            4'd4:    b = HUI_LEN_LO;
            4'd5:    b = HUI_LEN_HI;
            4'd6:    b = HUI_CKA;
            4'd7:    b = HUI_CKB;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic grft_res_t tx_res(input logic [BYTE_W-1:0] b, input logic last);
        grft_res_t r;
        r           = '0;
        r.kind      = 1'b1;
        r.tx        = b;
        r.frame_end = last;
        return r;
    endfunction

    function automatic grft_res_t status_res(input grft_job_t j);
        grft_res_t r;
        r         = '0;
        r.run_end = 1'b1;
        r.time_ms = j.time_ms;
        r.sats    = j.sats;
        r.fresh   = j.fresh;
        return r;
    endfunction

endpackage

[rtl/grft_front.sv]
`timescale 1ns / 1ps
`include "gnss_raw_frame_tracker_defines.svh"

module grft_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [grft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grft_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [grft_pkg::BYTE_W-1:0]        s_rx_byte,
    input  logic                               adv,
    input  logic                               wb_valid,
    input  logic [grft_pkg::TIME_W-1:0]        wb_time,
    output logic                               s0_valid,
    output grft_pkg::grft_stage_t              s0_stage
);
    import grft_pkg::*;

    logic [BYTE_W-1:0] class_reg, id_reg, interval_reg, last_svid_reg;
    logic [HP_W-1:0]   hdr_reg, hdr_next, pos;
    logic [TIME_W-1:0] time_reg, time_next, time_upd;
    logic [BYTE_W-1:0] sats_reg, sats_next;
    logic              fresh_reg, fresh_next;
    logic [BYTE_W-1:0] cd_reg, cd_next, cd_dec;
    logic [BYTE_W-1:0] sv_reg, sv_next, sv_inc;
    logic              pending_reg, pending_next;
    logic              s0_valid_reg;
    grft_stage_t       s0_reg;
    logic              accept;
    logic              origin, eph, health;
    logic [1:0]        byte_sel;

    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg     <= CLASS_RST;
            id_reg        <= ID_RST;
            interval_reg  <= INTERVAL_RST;
            last_svid_reg <= LAST_SVID_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MATCH_CLASS:   class_reg     <= cfg_wdata;
                REG_MATCH_ID:      id_reg        <= cfg_wdata;
                REG_POLL_INTERVAL: interval_reg  <= cfg_wdata;
                REG_LAST_SVID:     last_svid_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // header match, time/count capture and poll decision
    always_comb begin
        hdr_next   = hdr_reg;
        time_upd   = time_reg;
        sats_next  = sats_reg;
        fresh_next = fresh_reg;
        cd_next    = cd_reg;
        sv_next    = sv_reg;
        origin     = 1'b0;
        eph        = 1'b0;
        health     = 1'b0;
        pos        = hdr_reg + 4'd1;
        cd_dec     = cd_reg - 8'd1;
        sv_inc     = sv_reg + 8'd1;
        byte_sel   = 2'(pos - HP_TIME_FIRST);
        if (accept) begin
            unique case (hdr_reg)
                HP_IDLE: begin
                    if (s_rx_byte == SYNC_1) hdr_next = HP_GOT_SYNC1;
                end
                HP_GOT_SYNC1: hdr_next = (s_rx_byte == SYNC_2) ? HP_GOT_SYNC2 : HP_IDLE;
                HP_GOT_SYNC2: hdr_next = (s_rx_byte == class_reg) ? HP_GOT_CLASS : HP_IDLE;
                HP_GOT_CLASS: hdr_next = (s_rx_byte == id_reg) ? pos : HP_IDLE;
                default: begin
                    hdr_next = pos;
                    if (pos >= HP_TIME_FIRST && pos <= HP_TIME_LAST) begin
                        if (pos == HP_TIME_FIRST) fresh_next = 1'b0;
                        for (int b = 0; b < 4; b++) begin
                            if (byte_sel == 2'(b)) time_upd[8*b +: 8] = s_rx_byte;
                        end
                        origin = (pos == HP_TIME_LAST) && (time_upd != '0)
                                 && !time_upd[TIME_W-1];
                    end else if (pos >= HP_SATS) begin
                        sats_next  = s_rx_byte;
                        fresh_next = 1'b1;
                        hdr_next   = HP_IDLE;
                        cd_next    = cd_dec;
                        if (cd_dec == '0) begin
                            cd_next = interval_reg;
                            sv_next = sv_inc;
                            eph     = 1'b1;
                            if (sv_inc == last_svid_reg) begin
                                health  = 1'b1;
                                sv_next = '0;
                            end
                        end
                    end
                end
            endcase
        end
        // rounded time comes back from the rounding pipe
        time_next    = wb_valid ? wb_time : time_upd;
        pending_next = (accept && origin) ? 1'b1 : (wb_valid ? 1'b0 : pending_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg      <= HP_IDLE;
            time_reg     <= '0;
            sats_reg     <= '0;
            fresh_reg    <= 1'b0;
            cd_reg       <= INTERVAL_RST;
            sv_reg       <= '0;
            pending_reg  <= 1'b0;
            s0_valid_reg <= 1'b0;
        end else begin
            hdr_reg     <= hdr_next;
            time_reg    <= time_next;
            sats_reg    <= sats_next;
            fresh_reg   <= fresh_next;
            cd_reg      <= cd_next;
            sv_reg      <= sv_next;
            pending_reg <= pending_next;
            if (adv) s0_valid_reg <= accept;
        end
    end

    // front output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_reg.job.time_ms <= time_upd;
            s0_reg.job.sats    <= sats_next;
            s0_reg.job.fresh   <= fresh_next;
            s0_reg.job.eph     <= eph;
            s0_reg.job.svid    <= sv_inc;
            s0_reg.job.health  <= health;
            s0_reg.need_round  <= origin || pending_reg;
            s0_reg.wb          <= origin;
        end
    end

    assign s0_valid = s0_valid_reg;
    assign s0_stage = s0_reg;

    `GRFT_ASSERT_IMP(a_wb_needs_pending, wb_valid, pending_reg)

endmodule

[rtl/grft_round.sv]
`timescale 1ns / 1ps

module grft_round (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        s0_valid,
    input  grft_pkg::grft_stage_t       s0_stage,
    output logic                        s2_valid,
    output grft_pkg::grft_job_t         s2_job,
    output logic                        s2_wb,
    output logic [grft_pkg::TIME_W-1:0] s2_round_time
);
    import grft_pkg::*;

    logic              s1_valid_reg, s2_valid_reg;
    grft_stage_t       s1_reg, s2_reg;
    logic [Q_W-1:0]    s1_q_reg;
    logic [TIME_W-1:0] s2_rounded_reg;
    logic [62:0]       prod;
    logic [32:0]       up_full;

    // quotient by reciprocal multiply
    assign prod = {32'd0, s0_stage.job.time_ms[TIME_W-2:0]} * {31'd0, RECIP};

    // next multiple of 1000 above the time, modulo 2^32
    assign up_full = 33'({1'b0, s1_q_reg} + 23'd1) * 33'(MS_PER_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s0_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg         <= s0_stage;
            s1_q_reg       <= prod[RECIP_SHIFT +: Q_W];
            s2_reg         <= s1_reg;
            s2_rounded_reg <= up_full[TIME_W-1:0];
        end
    end

    // pick rounded or raw time for the status snapshot
    always_comb begin
        s2_job = s2_reg.job;
        if (s2_reg.need_round) s2_job.time_ms = s2_rounded_reg;
    end

    assign s2_valid      = s2_valid_reg;
    assign s2_wb         = s2_reg.wb;
    assign s2_round_time = s2_rounded_reg;

endmodule

[rtl/grft_queue.sv]
`timescale 1ns / 1ps
`include "gnss_raw_frame_tracker_defines.svh"

module grft_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  grft_pkg::grft_job_t din,
    input  logic                pop,
    output grft_pkg::grft_job_t head,
    output logic                full,
    output logic                empty
);
    import grft_pkg::*;

    grft_job_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= din;
    end

    `GRFT_ASSERT_IMP(a_q_no_overflow, push, !full)
    `GRFT_ASSERT_IMP(a_q_no_underflow, pop, !empty)
    `GRFT_ASSERT_NXT(a_q_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

[rtl/grft_back.sv]
`timescale 1ns / 1ps
`include "gnss_raw_frame_tracker_defines.svh"

module grft_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  grft_pkg::grft_job_t         head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output grft_pkg::grft_res_t         m_res
);
    import grft_pkg::*;

    grft_bstate_t      st_reg, st_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    grft_res_t         res_cur, res_reg;
    logic              m_valid_reg;
    logic              out_load;

    assign out_load = !q_empty && (!m_valid_reg || m_ready);
    assign pop      = out_load && res_cur.run_end;

    // result selected for the current sequencer step
    always_comb begin
        unique case (st_reg)
            ST_FIRST:  res_cur = head.eph ? tx_res(eph_byte('0, head.svid), 1'b0)
                                          : status_res(head);
            ST_EPH:    res_cur = tx_res(eph_byte(idx_reg, head.svid), idx_reg == EPH_LAST);
            ST_HEALTH: res_cur = tx_res(hui_byte(idx_reg), idx_reg == HUI_LAST);
            ST_STATUS: res_cur = status_res(head);
            default:   res_cur = status_res(head);
        endcase
    end

    // sequencer next state
    always_comb begin
        st_next  = st_reg;
        idx_next = idx_reg;
        if (out_load) begin
            unique case (st_reg)
                ST_FIRST: begin
                    if (head.eph) begin
                        st_next  = ST_EPH;
                        idx_next = 4'd1;
                    end
                end
                ST_EPH: begin
                    if (idx_reg == EPH_LAST) begin
                        st_next  = head.health ? ST_HEALTH : ST_STATUS;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                ST_HEALTH: begin
                    if (idx_reg == HUI_LAST) begin
                        st_next  = ST_STATUS;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                ST_STATUS: begin
                    st_next  = ST_FIRST;
                    idx_next = '0;
                end
                default: begin
                    st_next  = ST_FIRST;
                    idx_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_FIRST;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) res_reg <= res_cur;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    `GRFT_ASSERT_IMP(a_mid_frame_has_head, st_reg != ST_FIRST, !q_empty)
    `GRFT_ASSERT_IMP(a_frame_end_is_tx, m_valid_reg && res_reg.frame_end, res_reg.kind)

endmodule

[rtl/gnss_raw_frame_tracker.sv]
`timescale 1ns / 1ps
// A status result follows the poll bytes its byte triggers, after the front register, the
// two-stage divide-by-1000 pipeline, the 4-entry queue that absorbs polls and the output register.
// Throughput: one byte per cycle unless a full queue stalls the pipe; a byte that triggers polls
// holds the single result port for its ephemeris frame, any health frame and its status result.
// Reset (aresetn low, synchronous): registers to defaults, matcher idle, queue and output empty.

module gnss_raw_frame_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [grft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grft_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [grft_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_result_kind,
    output logic [grft_pkg::BYTE_W-1:0]        m_tx_byte,
    output logic                               m_frame_end,
    output logic                               m_run_end,
    output logic signed [grft_pkg::TIME_W-1:0] m_time_ms,
    output logic [grft_pkg::BYTE_W-1:0]        m_sat_count,
    output logic                               m_fresh
);
    import grft_pkg::*;

    logic              adv;
    logic              s0_valid, s2_valid, s2_wb;
    grft_stage_t       s0_stage;
    grft_job_t         s2_job, q_head;
    logic [TIME_W-1:0] s2_round_time;
    logic              push, wb_valid, q_full, q_empty, q_pop;
    grft_res_t         m_res;

    // the front pipe moves as one unless its last stage waits on a full queue
    assign adv      = !(s2_valid && q_full);
    assign push     = s2_valid && adv;
    assign wb_valid = push && s2_wb;

    grft_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .adv       (adv),
        .wb_valid  (wb_valid),
        .wb_time   (s2_round_time),
        .s0_valid  (s0_valid),
        .s0_stage  (s0_stage)
    );

    grft_round u_round (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .s0_valid      (s0_valid),
        .s0_stage      (s0_stage),
        .s2_valid      (s2_valid),
        .s2_job        (s2_job),
        .s2_wb         (s2_wb),
        .s2_round_time (s2_round_time)
    );

    grft_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (s2_job),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    grft_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_result_kind = m_res.kind;
    assign m_tx_byte     = m_res.tx;
    assign m_frame_end   = m_res.frame_end;
    assign m_run_end     = m_res.run_end;
    assign m_time_ms     = $signed(m_res.time_ms);
    assign m_sat_count   = m_res.sats;
    assign m_fresh       = m_res.fresh;

endmodule
